// ===== hdl/nnt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour tour package
// Shared widths, defaults, command and result types for the tour block.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int unsigned CITY_W        = 4;
  localparam int unsigned WEIGHT_W      = 16;
  localparam int unsigned N_CITIES_DEF  = 16;
  localparam int unsigned CMD_DEPTH_DEF = 4;
  localparam int unsigned RES_DEPTH_DEF = 4;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_TOUR = 1'b1
  } cmd_kind_e;

  // city_a is the row of a load or the start city of a tour
  typedef struct packed {
    cmd_kind_e           kind;
    logic [CITY_W-1:0]   city_a;
    logic [CITY_W-1:0]   city_b;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic              by_fallback;
    logic              last;
  } res_t;

endpackage

// ===== hdl/nnt_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour tour queue
// Small first-in first-out queue of registers; depth must be a power of two, which the queue does not enforce.
// ----------------------------------------------------------------------------
module nnt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = nnt_pkg::CMD_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hdl/nnt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour tour front end
// Accepts input transactions, classifies them as load or tour and drops
// those whose city indices lie outside the matrix.
// ----------------------------------------------------------------------------
module nnt_front #(
  parameter int unsigned N_CITIES = nnt_pkg::N_CITIES_DEF
) (
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          mode_i,
  input  logic [nnt_pkg::CITY_W-1:0]    from_city_i,
  input  logic [nnt_pkg::CITY_W-1:0]    to_city_i,
  input  logic signed [nnt_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [nnt_pkg::CITY_W-1:0]    start_city_i,
  input  logic                          cmd_full_i,
  output logic                          cmd_push_o,
  output nnt_pkg::cmd_t                 cmd_o
);

  logic accept;
  logic in_range;

  assign full_o = cmd_full_i;
  assign accept = push_i && !cmd_full_i;

  always_comb begin
    cmd_o.weight = weight_i;
    if (mode_i) begin
      cmd_o.kind   = nnt_pkg::CMD_TOUR;
      cmd_o.city_a = start_city_i;
      cmd_o.city_b = '0;
      in_range     = (32'(start_city_i) < N_CITIES);
    end else begin
      cmd_o.kind   = nnt_pkg::CMD_LOAD;
      cmd_o.city_a = from_city_i;
      cmd_o.city_b = to_city_i;
      in_range     = (32'(from_city_i) < N_CITIES) && (32'(to_city_i) < N_CITIES);
    end
  end

  // drop out-of-range transactions once accepted
  assign cmd_push_o = accept && in_range;

endmodule

// ===== hdl/nnt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour tour engine
// Holds the weight matrix, executes loads and walks tours: each step scans
// one matrix row, one entry a cycle, and pushes the chosen city.
// ----------------------------------------------------------------------------
module nnt_back #(
  parameter int unsigned N_CITIES = nnt_pkg::N_CITIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  nnt_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output nnt_pkg::res_t res_o
);

  localparam int unsigned CW        = $clog2(N_CITIES);
  localparam int unsigned MEM_DEPTH = 1 << (2 * CW);
  localparam int unsigned CNT_W     = $clog2(N_CITIES + 1);
  localparam int unsigned WW        = nnt_pkg::WEIGHT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RESULT = 3'b010,
    ST_SCAN   = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        cur_q, cur_d;
  logic [N_CITIES-1:0]  visited_q, visited_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic                 iss_q, iss_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic [WW-1:0]        rd_data_q;
  logic [WW-1:0]        best_q, best_d;
  logic                 found_q, found_d;
  logic [CW-1:0]        pick_q, pick_d;
  logic [CW-1:0]        first_q, first_d;
  logic                 first_ok_q, first_ok_d;
  logic                 res_fb_q, res_fb_d;
  logic                 res_last_q, res_last_d;

  logic [WW-1:0]        mem_q [MEM_DEPTH];

  logic                 w_ok, unv, scan_done;
  logic [WW-1:0]        best_nx;
  logic                 found_nx, first_ok_nx;
  logic [CW-1:0]        pick_nx, first_nx;

  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;
  assign res_push_o = (state_q == ST_RESULT) && !res_full_i;

  assign res_o.city        = nnt_pkg::CITY_W'(cur_q);
  assign res_o.by_fallback = res_fb_q;
  assign res_o.last        = res_last_q;

  // candidate update from the entry read last cycle
  assign unv  = rd_vld_q && !visited_q[rd_idx_q];
  assign w_ok = unv && !rd_data_q[WW-1] && (!found_q || (rd_data_q < best_q));
  assign found_nx    = found_q || w_ok;
  assign best_nx     = w_ok ? rd_data_q : best_q;
  assign pick_nx     = w_ok ? rd_idx_q : pick_q;
  assign first_nx    = (unv && !first_ok_q) ? rd_idx_q : first_q;
  assign first_ok_nx = first_ok_q || unv;
  assign scan_done   = rd_vld_q && (rd_idx_q == CW'(N_CITIES - 1));

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    visited_d  = visited_q;
    cnt_d      = cnt_q;
    scan_d     = scan_q;
    iss_d      = iss_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = scan_q;
    best_d     = best_q;
    found_d    = found_q;
    pick_d     = pick_q;
    first_d    = first_q;
    first_ok_d = first_ok_q;
    res_fb_d   = res_fb_q;
    res_last_d = res_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i && (cmd_i.kind == nnt_pkg::CMD_TOUR)) begin
          cur_d      = CW'(cmd_i.city_a);
          visited_d  = '0;
          cnt_d      = '0;
          res_fb_d   = 1'b0;
          res_last_d = 1'b0;
          state_d    = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!res_full_i) begin
          visited_d[cur_q] = 1'b1;
          cnt_d            = cnt_q + CNT_W'(1);
          if (res_last_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d    = ST_SCAN;
            scan_d     = '0;
            iss_d      = 1'b1;
            found_d    = 1'b0;
            first_ok_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (iss_q) begin
          rd_vld_d = 1'b1;
          if (scan_q == CW'(N_CITIES - 1)) begin
            iss_d = 1'b0;
          end else begin
            scan_d = scan_q + CW'(1);
          end
        end
        best_d     = best_nx;
        found_d    = found_nx;
        pick_d     = pick_nx;
        first_d    = first_nx;
        first_ok_d = first_ok_nx;
        if (scan_done) begin
          cur_d      = found_nx ? pick_nx : first_nx;
          res_fb_d   = !found_nx;
          res_last_d = (cnt_q == CNT_W'(N_CITIES - 1));
          state_d    = ST_RESULT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_i.kind == nnt_pkg::CMD_LOAD)) begin
      mem_q[{CW'(cmd_i.city_a), CW'(cmd_i.city_b)}] <= cmd_i.weight;
    end
    rd_data_q <= mem_q[{cur_q, scan_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_q      <= '0;
      visited_q  <= '0;
      cnt_q      <= '0;
      scan_q     <= '0;
      iss_q      <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      found_q    <= 1'b0;
      first_ok_q <= 1'b0;
      res_fb_q   <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      visited_q  <= visited_d;
      cnt_q      <= cnt_d;
      scan_q     <= scan_d;
      iss_q      <= iss_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      found_q    <= found_d;
      first_ok_q <= first_ok_d;
      res_fb_q   <= res_fb_d;
      res_last_q <= res_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    pick_q  <= pick_d;
    first_q <= first_d;
  end

  a_push_unvisited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !visited_q[cur_q])
    else $error("tour city emitted twice");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(N_CITIES))
    else $error("more cities emitted than the matrix holds");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_last_q) |=> (state_q == ST_IDLE))
    else $error("engine busy after final city");

  a_unvisited_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_done) |-> first_ok_nx)
    else $error("row scan ended with no unvisited city");

endmodule

// ===== hdl/nearest_neighbour_tour.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour tour
// Greedy nearest-neighbour tour over a signed weight matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive the fields and raise push; the transaction is taken at
//   a clock edge with push high and full low. Mode 0 writes one matrix entry,
//   mode 1 starts a tour from start_city.
//   Out-of-range cities are taken and dropped without a result.
//   Result queue: while empty is low, city, by_fallback and last show the
//   oldest result; pop takes it. A tour yields N_CITIES results, the last
//   with last set.
//   A start transaction taken by an idle engine shows its start city as the
//   first result; each later city comes from a scan of one matrix row read
//   through the single memory read port, one entry a cycle.
//   Reset clears both queues and the engine; matrix contents are undefined
//   until written. A stalled result queue holds the engine, and a full
//   command queue holds the input side, each without loss.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour #(
  parameter int unsigned N_CITIES  = nnt_pkg::N_CITIES_DEF,
  parameter int unsigned CMD_DEPTH = nnt_pkg::CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = nnt_pkg::RES_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                mode_i,
  input  logic [nnt_pkg::CITY_W-1:0]          from_city_i,
  input  logic [nnt_pkg::CITY_W-1:0]          to_city_i,
  input  logic signed [nnt_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [nnt_pkg::CITY_W-1:0]          start_city_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [nnt_pkg::CITY_W-1:0]          city_o,
  output logic                                by_fallback_o,
  output logic                                last_o
);

  localparam int unsigned CMD_W = $bits(nnt_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(nnt_pkg::res_t);

  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  nnt_pkg::cmd_t cmd_in, cmd_out;
  logic          res_push, res_full;
  nnt_pkg::res_t res_in, res_out;

  nnt_front #(
    .N_CITIES(N_CITIES)
  ) u_front (
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .from_city_i (from_city_i),
    .to_city_i   (to_city_i),
    .weight_i    (weight_i),
    .start_city_i(start_city_i),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  nnt_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  nnt_back #(
    .N_CITIES(N_CITIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  nnt_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign city_o        = res_out.city;
  assign by_fallback_o = res_out.by_fallback;
  assign last_o        = res_out.last;

endmodule
